[rtl/slc_pkg.sv]
// shared types and constants for the serial line collector
package slc_pkg;

   localparam int LINE_BYTES_DEF = 32;
   localparam int LINE_IDX_W     = 8;   // wide enough for the largest line store
   localparam int LEN_W          = 5;
   localparam int TIMEOUT_W      = 16;
   localparam int ELAPSED_W      = 17;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = 17'h1FFFF;
   localparam logic [7:0]           CHAR_CR       = 8'h0D;
   localparam logic [7:0]           CHAR_LF       = 8'h0A;
   localparam logic [7:0]           CHAR_SPACE    = 8'h20;

   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_READY     = 3'd1,
      EV_TIMEOUT   = 3'd2,
      EV_DISCARDED = 3'd3,
      EV_TOOLONG   = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      CMD_ECHO,
      CMD_LINE,
      CMD_TIMEOUT
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_SEND
   } back_state_type;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]       event_res;
      logic             echo_valid;
      logic [7:0]       echo_byte;
      logic [LEN_W-1:0] line_length;
      logic             line_byte_valid;
      logic [7:0]       line_byte;
      logic             last;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [2:0]            event_res;
      logic [7:0]            rx_byte;
      logic                  wr_en;
      logic [LINE_IDX_W-1:0] idx;
      logic [LINE_IDX_W-1:0] len;
   } cmd_type;

endpackage

[rtl/slc_front.sv]
// front end: accepts requests, classifies them and tracks line state
module slc_front #(
   parameter int LINE_BYTES = slc_pkg::LINE_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  slc_pkg::req_type                req_payload,
   input  logic                            csr_valid,
   input  logic [slc_pkg::TIMEOUT_W-1:0]   csr_data,
   output logic                            cmd_push,
   output slc_pkg::cmd_type                cmd,
   input  logic                            cmd_full
);
   import slc_pkg::*;

   localparam int FILL_W = $clog2(LINE_BYTES);
   localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(LINE_BYTES - 1);

   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic                 discard_ff, discard_in;
   logic                 timer_ff, timer_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic                 accept;
   logic [ELAPSED_W-1:0] elapsed_inc;
   logic [7:0]           c;

   assign req_stall   = cmd_full;
   assign accept      = req_valid && !cmd_full;
   assign c           = req_payload.rx_byte;
   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 1'b1;

   always_comb begin
      fill_in    = fill_ff;
      discard_in = discard_ff;
      timer_in   = timer_ff;
      elapsed_in = elapsed_ff;
      cmd_push   = 1'b0;
      cmd        = '{kind: CMD_ECHO, event_res: EV_NONE, rx_byte: c, wr_en: 1'b0,
                     idx: '0, len: '0};
      if (accept) begin
         if (req_payload.action == ACT_TICK) begin
            if (timer_ff) begin
               if (elapsed_inc > {1'b0, timeout_ff}) begin
                  fill_in       = '0;
                  discard_in    = 1'b0;
                  timer_in      = 1'b0;
                  elapsed_in    = '0;
                  cmd_push      = 1'b1;
                  cmd.kind      = CMD_TIMEOUT;
                  cmd.event_res = EV_TIMEOUT;
                  cmd.rx_byte   = '0;
               end else begin
                  elapsed_in = elapsed_inc;
               end
            end
         end else begin
            cmd_push = 1'b1;
            if (!timer_ff) begin
               timer_in   = 1'b1;
               elapsed_in = '0;
            end
            if (c == CHAR_CR || c == CHAR_LF) begin
               if (discard_ff) begin
                  cmd.event_res = EV_DISCARDED;
               end else begin
                  cmd.kind      = CMD_LINE;
                  cmd.event_res = EV_READY;
                  cmd.len       = LINE_IDX_W'(fill_ff);
               end
               fill_in    = '0;
               discard_in = 1'b0;
               timer_in   = 1'b0;
               elapsed_in = '0;
            end else if (c < CHAR_SPACE) begin
               discard_in = 1'b1;
            end else if (discard_ff) begin
               // printable byte dropped while discarding
            end else if (fill_ff >= FILL_LIMIT) begin
               fill_in       = '0;
               cmd.event_res = EV_TOOLONG;
            end else begin
               cmd.wr_en = 1'b1;
               cmd.idx   = LINE_IDX_W'(fill_ff);
               fill_in   = fill_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         discard_ff <= 1'b0;
         timer_ff   <= 1'b0;
         elapsed_ff <= '0;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         fill_ff    <= fill_in;
         discard_ff <= discard_in;
         timer_ff   <= timer_in;
         elapsed_ff <= elapsed_in;
         if (csr_valid) begin
            timeout_ff <= csr_data;
         end
      end
   end

endmodule

[rtl/slc_queue.sv]
// small command queue between front and back
module slc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  slc_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output slc_pkg::cmd_type head,
   output logic             empty
);
   import slc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/slc_back.sv]
// back end: line store, result formatting and line streaming
module slc_back #(
   parameter int LINE_BYTES = slc_pkg::LINE_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  slc_pkg::cmd_type head,
   input  logic             empty,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output slc_pkg::rsp_type rsp_payload
);
   import slc_pkg::*;

   localparam int IDX_W = $clog2(LINE_BYTES);

   logic [7:0]     store_mem [LINE_BYTES];
   logic [7:0]     rd_data_ff;
   back_state_type state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] len_ff, len_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;
   logic           out_free;
   logic           stream_last;
   logic           head_streams;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign stream_last  = (cnt_ff == len_ff - IDX_W'(1));
   assign head_streams = (head.kind == CMD_LINE) && (head.len != '0);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!empty && out_free && head_streams) begin
               state_in = BK_READ;
            end
         end
         BK_READ: state_in = BK_SEND;
         BK_SEND: begin
            if (out_free) begin
               state_in = stream_last ? BK_IDLE : BK_READ;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop          = 1'b0;
      cnt_in       = cnt_ff;
      len_in       = len_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         BK_IDLE: begin
            if (!empty && out_free) begin
               pop                    = 1'b1;
               rsp_valid_in           = 1'b1;
               rsp_in                 = '0;
               rsp_in.event_res       = head.event_res;
               rsp_in.echo_valid      = (head.kind != CMD_TIMEOUT);
               rsp_in.echo_byte       = head.rx_byte;
               rsp_in.line_length     = head.len[LEN_W-1:0];
               rsp_in.last            = !head_streams;
               cnt_in                 = '0;
               len_in                 = head.len[IDX_W-1:0];
            end
         end
         BK_READ: begin
         end
         BK_SEND: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in                 = '0;
               rsp_in.event_res       = EV_NONE;
               rsp_in.line_byte_valid = 1'b1;
               rsp_in.line_byte       = rd_data_ff;
               rsp_in.last            = stream_last;
               cnt_in                 = cnt_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pop && head.wr_en) begin
         store_mem[head.idx[IDX_W-1:0]] <= head.rx_byte;
      end
      rd_data_ff <= store_mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      cnt_ff <= cnt_in;
      len_ff <= len_in;
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/serial_line_collector.sv]
// top level of the serial line collector
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  slc_pkg::req_type (action, rx_byte)
//  rsp      out        rsp_valid/rsp_stall  slc_pkg::rsp_type (event, echo, line data)
//  csr      in         csr_valid/csr_ready  timeout_ticks, 16 bits
//
// a byte request gives its echo result once its command has passed the command queue and the output register
// a line end streams its stored bytes one after another, each through the
// registered read of the line store ahead of the output register
// reset is synchronous; the line store is not cleared, but the fill count and other control registers are reset
// requests keep being taken until the four-entry command queue fills up
module serial_line_collector #(
   parameter int LINE_BYTES = slc_pkg::LINE_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  slc_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output slc_pkg::rsp_type              rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [slc_pkg::TIMEOUT_W-1:0] csr_data
);
   import slc_pkg::*;

   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    push;
   logic    full;
   logic    pop;
   logic    empty;

   // the timeout register takes a write in any cycle
   assign csr_ready = 1'b1;

   // front end: classify each request, update fill count, discard and timer
   slc_front #(
      .LINE_BYTES(LINE_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .csr_valid  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .cmd_push   (push),
      .cmd        (push_cmd),
      .cmd_full   (full)
   );

   // queue keeps store writes ordered behind earlier line drains
   slc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_cmd),
      .full     (full),
      .pop      (pop),
      .head     (head_cmd),
      .empty    (empty)
   );

   // back end: writes the line store and formats every result
   slc_back #(
      .LINE_BYTES(LINE_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_cmd),
      .empty      (empty),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

[rtl/slc_checker.sv]
// port-level checks for the serial line collector, bound to the top level
module slc_port_checks (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input slc_pkg::rsp_type rsp_payload
);
   import slc_pkg::*;

   // no result is offered right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // streamed line bytes carry nothing else
   a_stream_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.line_byte_valid |->
         rsp_payload.event_res == EV_NONE && !rsp_payload.echo_valid &&
         rsp_payload.line_length == '0)
      else $error("line byte result carries other fields");

   // a timeout is a single result with no echo
   a_timeout_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.event_res == EV_TIMEOUT |->
         rsp_payload.last && !rsp_payload.echo_valid)
      else $error("timeout result malformed");

   // the line stream closes before a new echo appears
   a_stream_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_payload.line_byte_valid && !rsp_payload.last |=>
         !rsp_valid || rsp_payload.line_byte_valid)
      else $error("line stream interrupted");

endmodule

bind serial_line_collector slc_port_checks u_slc_port_checks (.*);
